[design/mfu_pkg.sv]
// ----------------------------------------------------------------------------
// mfu_pkg: shared types and constants for the marker frame unstuffer
// markers, default byte limit and the op word passed from front to back
// ----------------------------------------------------------------------------
`default_nettype none

package mfu_pkg;

  localparam logic [7:0] MARK_ESC   = 8'd253;
  localparam logic [7:0] MARK_START = 8'd254;
  localparam logic [7:0] MARK_END   = 8'd255;

  localparam int unsigned MAX_MESSAGE = 64;

  // absolute cap so the kept count fits 7 bits
  localparam int unsigned COUNT_CAP = 127;

  typedef enum logic {
    OP_DATA,
    OP_END
  } mfu_op_e;

  // one queued op: a decoded data byte, or an end of frame
  // value is the data byte, or the declared count on an end op
  typedef struct packed {
    mfu_op_e    kind;
    logic [7:0] value;
    logic       dangling;
  } mfu_op_t;

endpackage

`default_nettype wire

[design/marker_frame_unstuffer.sv]
// ----------------------------------------------------------------------------
// marker_frame_unstuffer: start/end marker deframer with escape unstuffing
// path: a taken byte is decoded and queued, then written to the output register
// throughput: one byte per cycle while the queue is not full; the front
// stalls the input once the two-entry queue fills under output stall
// reset: asynchronous, active low; idle phase, counts and flags cleared
// ----------------------------------------------------------------------------
`default_nettype none

module marker_frame_unstuffer #(
  parameter int unsigned MaxMessage = mfu_pkg::MAX_MESSAGE
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input beat channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  // result beat channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      data_byte_o,
  output logic            frame_end_o,
  output logic [7:0]      declared_count_o,
  output logic [6:0]      decoded_count_o,
  output logic            overflow_o,
  output logic            dangling_escape_o
);
  import mfu_pkg::*;

  logic    q_full, q_valid, push, pop, accept;
  mfu_op_t push_op, head_op;

  // front stalls only on a full queue, never on the output side directly
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // front: phase tracking, count capture, escape decode
  mfu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .op_o      (push_op),
    .push_o    (push)
  );

  // decouples the byte stream from output back-pressure
  mfu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (head_op)
  );

  // back: byte limit, overflow tracking, end report and output register
  mfu_back #(
    .MaxMessage (MaxMessage)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_op_i            (head_op),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .data_byte_o       (data_byte_o),
    .frame_end_o       (frame_end_o),
    .declared_count_o  (declared_count_o),
    .decoded_count_o   (decoded_count_o),
    .overflow_o        (overflow_o),
    .dangling_escape_o (dangling_escape_o)
  );

endmodule

`default_nettype wire

[design/mfu_front.sv]
// ----------------------------------------------------------------------------
// mfu_front: frame tracker and classifier
// follows the marker phase, holds the count byte and pushes data/end ops
// ----------------------------------------------------------------------------
`default_nettype none

module mfu_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     rx_byte_i,
  output mfu_pkg::mfu_op_t    op_o,
  output logic                push_o
);
  import mfu_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COUNT,
    PH_DATA,
    PH_ESC
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_count_q, held_count_d;

  always_comb begin
    phase_d      = phase_q;
    held_count_d = held_count_q;
    push_o       = 1'b0;
    op_o         = '{kind: OP_DATA, value: rx_byte_i, dangling: 1'b0};
    if (accept_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == MARK_START) begin
            phase_d      = PH_COUNT;
            held_count_d = '0;
          end
        end
        PH_COUNT: begin
          held_count_d = rx_byte_i;
          phase_d      = PH_DATA;
        end
        PH_DATA, PH_ESC: begin
          priority if (rx_byte_i == MARK_END) begin
            push_o       = 1'b1;
            op_o         = '{kind: OP_END, value: held_count_q,
                             dangling: (phase_q == PH_ESC)};
            phase_d      = PH_IDLE;
            held_count_d = '0;
          end else if (phase_q == PH_ESC) begin
            push_o   = 1'b1;
            op_o.value = rx_byte_i + MARK_ESC;  // wraps mod 256
            phase_d  = PH_DATA;
          end else if (rx_byte_i == MARK_ESC) begin
            phase_d = PH_ESC;
          end else begin
            push_o = 1'b1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      held_count_q <= '0;
    end else begin
      phase_q      <= phase_d;
      held_count_q <= held_count_d;
    end
  end

endmodule

`default_nettype wire

[design/mfu_queue.sv]
// ----------------------------------------------------------------------------
// mfu_queue: two-entry op queue between front and back
// push and pop may happen in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mfu_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire mfu_pkg::mfu_op_t op_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output mfu_pkg::mfu_op_t      op_o
);
  import mfu_pkg::*;

  mfu_op_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign op_o    = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/mfu_back.sv]
// ----------------------------------------------------------------------------
// mfu_back: op executor and output register
// counts kept bytes, drops past the limit, builds the end-of-frame report
// ----------------------------------------------------------------------------
`default_nettype none

module mfu_back #(
  parameter int unsigned MaxMessage = mfu_pkg::MAX_MESSAGE
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire mfu_pkg::mfu_op_t q_op_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            data_byte_o,
  output logic                  frame_end_o,
  output logic [7:0]            declared_count_o,
  output logic [6:0]            decoded_count_o,
  output logic                  overflow_o,
  output logic                  dangling_escape_o
);
  import mfu_pkg::*;

  localparam int unsigned LimitInt =
    (MaxMessage > COUNT_CAP) ? COUNT_CAP : MaxMessage;
  localparam logic [6:0] Limit = 7'(LimitInt);

  logic [6:0] kept_q, kept_d;
  logic       ovf_q, ovf_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] data_q, data_d, decl_q, decl_d;
  logic [6:0] dcnt_q, dcnt_d;
  logic       end_q, end_d, ovf_out_q, ovf_out_d, dang_q, dang_d;

  // output register is free when empty or being taken
  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    kept_d      = kept_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    data_d      = data_q;
    end_d       = end_q;
    decl_d      = decl_q;
    dcnt_d      = dcnt_q;
    ovf_out_d   = ovf_out_q;
    dang_d      = dang_q;
    if (pop_o) begin
      unique case (q_op_i.kind)
        OP_DATA: begin
          if (kept_q >= Limit) begin
            ovf_d       = 1'b1;
            out_valid_d = 1'b0;
          end else begin
            kept_d      = kept_q + 7'd1;
            out_valid_d = 1'b1;
            data_d      = q_op_i.value;
            end_d       = 1'b0;
            decl_d      = '0;
            dcnt_d      = '0;
            ovf_out_d   = 1'b0;
            dang_d      = 1'b0;
          end
        end
        OP_END: begin
          out_valid_d = 1'b1;
          data_d      = '0;
          end_d       = 1'b1;
          decl_d      = q_op_i.value;
          dcnt_d      = kept_q;
          ovf_out_d   = ovf_q;
          dang_d      = q_op_i.dangling;
          kept_d      = '0;
          ovf_d       = 1'b0;
        end
        default: out_valid_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      kept_q      <= kept_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q    <= data_d;
    end_q     <= end_d;
    decl_q    <= decl_d;
    dcnt_q    <= dcnt_d;
    ovf_out_q <= ovf_out_d;
    dang_q    <= dang_d;
  end

  assign out_valid_o       = out_valid_q;
  assign data_byte_o       = data_q;
  assign frame_end_o       = end_q;
  assign declared_count_o  = decl_q;
  assign decoded_count_o   = dcnt_q;
  assign overflow_o        = ovf_out_q;
  assign dangling_escape_o = dang_q;

endmodule

`default_nettype wire

[bench/tb_marker_frame_unstuffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_marker_frame_unstuffer: self-checking bench for the marker deframer
// a short table of directed bytes, then random framed traffic with escapes,
// overflow, dangling escapes and noise; every result beat is compared field
// by field against a typed-in table beat or a behavioral deframer on accepted beats
// ----------------------------------------------------------------------------

module tb_marker_frame_unstuffer;
  import mfu_pkg::*;

  // bytes kept per frame before the overflow flag takes over
  localparam int unsigned KEEP_LIMIT = (MAX_MESSAGE > COUNT_CAP) ? COUNT_CAP : MAX_MESSAGE;

  localparam int NUM_DIRECTED = 25;
  localparam int ITEMS_PER_PHASE = 500;
  localparam int NUM_PHASES = 4;
  localparam int LONG_HOLD_CYCLES = 300;

  // idle and stall percentages, one entry per traffic phase
  localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 53, 0, 24};
  localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 53, 24};

  // deframer phase, mirrors the block's own framing state
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COUNT,
    PH_DATA,
    PH_ESC
  } deframe_phase_e;

  // one result beat, as seen on the output ports
  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic [7:0] declared;
    logic [6:0] decoded;
    logic       ovf;
    logic       dangling;
  } result_beat_t;

  // how the expectation of a table row is formed
  typedef enum logic [1:0] {
    ROW_PREDICT,  // taken from the deframer below
    ROW_NONE,     // typed in: no result beat
    ROW_RESULT    // typed in: exactly this result beat
  } row_kind_e;

  typedef struct {
    logic [7:0]   rx;
    row_kind_e    kind;
    result_beat_t beat;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] data_byte_o;
  logic       frame_end_o;
  logic [7:0] declared_count_o;
  logic [6:0] decoded_count_o;
  logic       overflow_o;
  logic       dangling_escape_o;

  marker_frame_unstuffer #(
    .MaxMessage(MAX_MESSAGE)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_byte_o      (data_byte_o),
    .frame_end_o      (frame_end_o),
    .declared_count_o (declared_count_o),
    .decoded_count_o  (decoded_count_o),
    .overflow_o       (overflow_o),
    .dangling_escape_o(dangling_escape_o)
  );

  // behavioral deframer state
  deframe_phase_e frame_phase;
  logic [7:0]     held_count;
  logic [6:0]     kept_count;
  logic           dropped_seen;

  // result beats still owed by the block, oldest first
  result_beat_t pending_beats[$];

  int mismatches;
  int framed_items;      // accepted bytes that are not idle noise
  int send_idle_pct;
  int recv_stall_pct;
  bit long_hold_req;

  // tag of the beat currently offered, read when it is accepted
  row_kind_e    offered_kind;
  result_beat_t offered_beat;

  stim_row_t directed [NUM_DIRECTED];

  // ---------------------------------------------------------------- clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- limit
  initial begin
    #2_000_000;
    $display("timeout: %0d result beats still outstanding", pending_beats.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- deframer
  function automatic result_beat_t data_beat(input logic [7:0] value);
    result_beat_t r;
    r = '0;
    r.data = value;
    return r;
  endfunction

  function automatic result_beat_t end_beat(input logic [7:0] declared, input logic [6:0] decoded,
                                            input logic ovf, input logic dangling);
    result_beat_t r;
    r = '0;
    r.frame_end = 1'b1;
    r.declared  = declared;
    r.decoded   = decoded;
    r.ovf       = ovf;
    r.dangling  = dangling;
    return r;
  endfunction

  function automatic void clear_frame();
    frame_phase  = PH_IDLE;
    held_count   = '0;
    kept_count   = '0;
    dropped_seen = 1'b0;
  endfunction

  // advance the deframer by one raw byte; returns 1 when a result beat is due
  function automatic bit deframe_byte(input logic [7:0] rx, output result_beat_t beat);
    logic [7:0] value;
    beat = '0;
    case (frame_phase)
      PH_IDLE: begin
        // everything but a start marker is line noise here
        if (rx == MARK_START) begin
          clear_frame();
          frame_phase = PH_COUNT;
        end
        return 1'b0;
      end
      PH_COUNT: begin
        // count byte is raw, markers included
        held_count  = rx;
        frame_phase = PH_DATA;
        return 1'b0;
      end
      default: ;
    endcase

    // end marker closes the frame, even right after an escape
    if (rx == MARK_END) begin
      beat = end_beat(held_count, kept_count, dropped_seen, frame_phase == PH_ESC);
      clear_frame();
      return 1'b1;
    end

    if (frame_phase == PH_ESC) begin
      frame_phase = PH_DATA;
      value = MARK_ESC + rx;  // wraps mod 256
    end else if (rx == MARK_ESC) begin
      frame_phase = PH_ESC;
      return 1'b0;
    end else begin
      value = rx;
    end

    // past the limit a data byte is dropped and only flagged
    if (kept_count >= KEEP_LIMIT) begin
      dropped_seen = 1'b1;
      return 1'b0;
    end
    kept_count = kept_count + 7'd1;
    beat = data_beat(value);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // input beats feed the deframer before the output beat of the same edge is checked
  always @(posedge clk_i) begin : beat_checker
    result_beat_t predicted;
    result_beat_t seen;
    result_beat_t want;
    bit           due;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (frame_phase != PH_IDLE || rx_byte_i == MARK_START) framed_items++;
        due = deframe_byte(rx_byte_i, predicted);
        case (offered_kind)
          ROW_PREDICT: if (due) pending_beats.push_back(predicted);
          ROW_RESULT:  pending_beats.push_back(offered_beat);
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        seen.data      = data_byte_o;
        seen.frame_end = frame_end_o;
        seen.declared  = declared_count_o;
        seen.decoded   = decoded_count_o;
        seen.ovf       = overflow_o;
        seen.dangling  = dangling_escape_o;
        if (pending_beats.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = pending_beats.pop_front();
          check_field("data_byte", seen.data, want.data);
          check_field("frame_end", {7'd0, seen.frame_end}, {7'd0, want.frame_end});
          check_field("declared_count", seen.declared, want.declared);
          check_field("decoded_count", {1'b0, seen.decoded}, {1'b0, want.decoded});
          check_field("overflow", {7'd0, seen.ovf}, {7'd0, want.ovf});
          check_field("dangling_escape", {7'd0, seen.dangling}, {7'd0, want.dangling});
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // random stall per cycle, or a long hold-off that backs the block up
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- sender
  // offer one byte, idling at random first; returns at the accepting edge
  task automatic send_byte(input logic [7:0] value, input row_kind_e kind = ROW_PREDICT,
                           input result_beat_t typed = '0);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'($urandom_range(255));
      @(negedge clk_i);
    end
    offered_kind = kind;
    offered_beat = typed;
    in_valid_i <= 1'b1;
    rx_byte_i  <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid and wait until the block owes nothing, plus its pipeline depth
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one frame with random content; a broken frame gets no trailing end marker
  task automatic send_frame(input bit broken);
    int         len;
    logic [7:0] rx;
    send_byte(MARK_START);
    case ($urandom_range(7))
      0: rx = MARK_ESC;
      1: rx = MARK_START;
      2: rx = MARK_END;
      3: rx = 8'd0;
      default: rx = 8'($urandom_range(255));
    endcase
    send_byte(rx);
    // mostly short frames, some long enough to run past the limit
    len = ($urandom_range(9) == 0) ? $urandom_range(KEEP_LIMIT - 4, KEEP_LIMIT + 16)
                                   : $urandom_range(0, 20);
    repeat (len) begin
      if ($urandom_range(99) < 15) begin
        send_byte(MARK_ESC);
        if ($urandom_range(31) == 0) rx = MARK_END;
        else if ($urandom_range(7) == 0) rx = MARK_START;
        else rx = 8'($urandom_range(255));
        send_byte(rx);
        // escape then end marker already closed the frame
        if (rx == MARK_END) return;
      end else begin
        send_byte(8'($urandom_range(254)));
      end
    end
    if (!broken) send_byte(MARK_END);
  endtask

  // ---------------------------------------------------------------- main
  initial begin : main
    int row;
    int ph_idx;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    rx_byte_i     = 8'd0;
    offered_kind  = ROW_PREDICT;
    offered_beat  = '0;
    mismatches    = 0;
    framed_items  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b0;
    clear_frame();

    directed = '{
      // noise before any frame is ignored
      '{8'h00, ROW_NONE,   '0},
      '{8'hFF, ROW_NONE,   '0},
      '{8'hFD, ROW_NONE,   '0},
      // start, then a raw end marker taken as the count
      '{8'hFE, ROW_NONE,   '0},
      '{8'hFF, ROW_NONE,   '0},
      '{8'h00, ROW_RESULT, data_beat(8'd0)},
      // start marker inside a frame is plain data
      '{8'hFE, ROW_RESULT, data_beat(8'd254)},
      // escape pairs: top value, escaped start, wrap to zero
      '{8'hFD, ROW_NONE,   '0},
      '{8'h02, ROW_RESULT, data_beat(8'd255)},
      '{8'hFD, ROW_NONE,   '0},
      '{8'hFE, ROW_RESULT, data_beat(8'd251)},
      '{8'hFD, ROW_NONE,   '0},
      '{8'h03, ROW_RESULT, data_beat(8'd0)},
      '{8'hFF, ROW_RESULT, end_beat(8'd255, 7'd5, 1'b0, 1'b0)},
      // escape as count, then escape right before the end marker
      '{8'hFE, ROW_NONE,   '0},
      '{8'hFD, ROW_NONE,   '0},
      '{8'hFD, ROW_NONE,   '0},
      '{8'hFF, ROW_RESULT, end_beat(8'd253, 7'd0, 1'b0, 1'b1)},
      // start marker as count, empty frame
      '{8'hFE, ROW_NONE,   '0},
      '{8'hFE, ROW_NONE,   '0},
      '{8'hFF, ROW_RESULT, end_beat(8'd254, 7'd0, 1'b0, 1'b0)},
      // ordinary short frame
      '{8'hFE, ROW_NONE,   '0},
      '{8'h00, ROW_NONE,   '0},
      '{8'h5A, ROW_PREDICT, '0},
      '{8'hFF, ROW_PREDICT, '0}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (row = 0; row < NUM_DIRECTED; row++)
      send_byte(directed[row].rx, directed[row].kind, directed[row].beat);
    drain_block();

    // traffic phases, each ended by a full drain with the sender paused
    for (ph_idx = 0; ph_idx < NUM_PHASES; ph_idx++) begin
      send_idle_pct  = SEND_IDLE_PCT[ph_idx];
      recv_stall_pct = RECV_STALL_PCT[ph_idx];
      // back-pressure burst at full input rate fills the block
      if (ph_idx == 0) long_hold_req = 1'b1;
      framed_items = 0;
      while (framed_items < ITEMS_PER_PHASE) begin
        // a little line noise now and then, may contain a start marker
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
        send_frame($urandom_range(9) == 0);
      end
      // close a frame left open so the next phase starts clean
      if (frame_phase != PH_IDLE) send_byte(MARK_END);
      drain_block();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d beats never seen", mismatches, pending_beats.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
